### hdl/bar_pkg.sv
package bar_pkg;

    localparam int MASK_W = 8;
    localparam int HOLD_W = 8;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 3;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [7:0] RST_REPEAT_DELAY    = 8'd20;
    localparam logic [7:0] RST_REPEAT_INTERVAL = 8'd5;
    localparam logic [7:0] RST_COMBO_WINDOW    = 8'd3;

    typedef enum logic [CFG_W-1:0] {
        CFG_REPEAT_DELAY    = 3'd0,
        CFG_REPEAT_INTERVAL = 3'd1,
        CFG_COMBO_WINDOW    = 3'd2,
        CFG_REPEAT_ENABLE   = 3'd3,
        CFG_REPEAT_CONFLICT = 3'd4,
        CFG_PAIR_A          = 3'd5,
        CFG_PAIR_B          = 3'd6
    } t_cfg_idx;

    typedef enum logic [0:0] {
        OP_TICK   = 1'b0,
        OP_IGNORE = 1'b1
    } t_op;

    // what a lane does with its hold timer on a tick
    typedef enum logic [1:0] {
        TMR_HOLD   = 2'd0,
        TMR_CLEAR  = 2'd1,
        TMR_STEP   = 2'd2,
        TMR_RELOAD = 2'd3
    } t_tmr_op;

    typedef struct packed {
        logic              op;
        logic [MASK_W-1:0] buttons;
    } t_in_item;

    typedef struct packed {
        logic              event_valid;
        logic [IDX_W-1:0]  event_button;
        logic              event_repeat;
        logic              event_suppressed;
        logic [MASK_W-1:0] click_mask;
        logic [MASK_W-1:0] repeat_mask;
        logic              combo_wait;
    } t_out_item;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic              pressed;
        logic              live;
        logic              fire;
        logic              act;
        logic [HOLD_W-1:0] t1;
    } t_lane_info;

endpackage

### hdl/bar_lane.sv
module bar_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cur,
    input  logic                     i_en,
    input  logic [bar_pkg::HOLD_W-1:0] i_delay,
    input  logic [bar_pkg::HOLD_W:0] i_thresh,
    input  logic                     i_upd,
    input  bar_pkg::t_tmr_op         i_op,
    output bar_pkg::t_lane_info      o_info
);
    import bar_pkg::*;

    logic [HOLD_W-1:0] r_timer;
    logic [HOLD_W-1:0] n_timer;
    logic [HOLD_W-1:0] t1;

    assign t1 = r_timer + HOLD_W'(1);

    always_comb begin
        o_info.pressed = i_cur;
        o_info.live    = (r_timer != HOLD_MAX);
        o_info.fire    = ({1'b0, t1} >= i_thresh);
        o_info.act     = (t1 >= i_delay) && i_en;
        o_info.t1      = t1;
    end

    always_comb begin
        case (i_op)
            TMR_HOLD:   n_timer = r_timer;
            TMR_CLEAR:  n_timer = '0;
            TMR_STEP:   n_timer = t1;
            TMR_RELOAD: n_timer = i_delay;
            default:    n_timer = r_timer;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
        end else if (i_upd) begin
            r_timer <= n_timer;
        end
    end

endmodule

### hdl/bar_merge.sv
module bar_merge #(
    parameter int BUTTONS = 8
) (
    input  bar_pkg::t_lane_info [BUTTONS-1:0] i_info,
    input  logic [bar_pkg::MASK_W-1:0]       i_ra,
    input  logic [bar_pkg::MASK_W-1:0]       i_proc,
    input  logic [bar_pkg::MASK_W-1:0]       i_conflict,
    input  logic [bar_pkg::MASK_W-1:0]       i_pair_a,
    input  logic [bar_pkg::MASK_W-1:0]       i_pair_b,
    input  logic [bar_pkg::HOLD_W-1:0]       i_window,
    output bar_pkg::t_tmr_op [BUTTONS-1:0]   o_tmr_op,
    output logic [bar_pkg::MASK_W-1:0]       o_ra,
    output logic [bar_pkg::MASK_W-1:0]       o_proc,
    output bar_pkg::t_out_item               o_res
);
    import bar_pkg::*;

    logic [MASK_W-1:0] ra;
    logic [MASK_W-1:0] cur;
    logic [MASK_W-1:0] clicked;
    logic [MASK_W-1:0] repeated;
    logic [MASK_W-1:0] either;
    logic [MASK_W-1:0] ev_bit;
    logic [HOLD_W-1:0] last_hold;
    logic [IDX_W-1:0]  idx;
    logic              single;
    logic              wait_combo;

    // sequential over lanes: a conflict clears repeat state seen by later lanes
    always_comb begin
        ra        = i_ra;
        cur       = '0;
        clicked   = '0;
        repeated  = '0;
        last_hold = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            o_tmr_op[i] = TMR_HOLD;
            cur[i]      = i_info[i].pressed;
            if (i_info[i].pressed) begin
                if (i_info[i].live) begin
                    o_tmr_op[i] = TMR_STEP;
                    if (ra[i]) begin
                        if (i_info[i].fire) begin
                            o_tmr_op[i] = TMR_RELOAD;
                            repeated[i] = 1'b1;
                        end
                    end else if (i_info[i].act) begin
                        ra[i] = 1'b1;
                        if (i_conflict != '0 && (ra & i_conflict) == i_conflict) begin
                            ra = '0;
                        end else begin
                            o_tmr_op[i] = TMR_RELOAD;
                            repeated[i] = 1'b1;
                        end
                    end else if (!i_proc[i]) begin
                        clicked[i] = 1'b1;
                        last_hold  = i_info[i].t1;
                    end
                end
            end else begin
                o_tmr_op[i] = TMR_CLEAR;
                ra[i]       = 1'b0;
            end
        end
    end

    always_comb begin
        idx = '0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (either[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

    assign either     = clicked | repeated;
    assign single     = (cur != '0) && ((cur & (cur - MASK_W'(1))) == '0);
    assign wait_combo = (repeated == '0) && single && (last_hold <= i_window);

    always_comb begin
        ev_bit = '0;
        o_res  = '0;
        o_res.click_mask  = clicked;
        o_res.repeat_mask = repeated;
        if (wait_combo) begin
            o_res.combo_wait = 1'b1;
        end else if (either != '0) begin
            ev_bit[idx]            = 1'b1;
            o_res.event_valid      = 1'b1;
            o_res.event_button     = idx;
            o_res.event_repeat     = repeated[idx];
            o_res.event_suppressed = (i_pair_a[idx] && ((ra & i_pair_b) != '0)) ||
                                     (i_pair_b[idx] && ((ra & i_pair_a) != '0));
        end
    end

    assign o_ra   = ra;
    assign o_proc = (i_proc & cur) | ev_bit;

endmodule

### hdl/button_auto_repeat_qualifier.sv
// an accepted request's result is registered into the output stage, or into the skid entry if that stage is full
// throughput: one request per cycle while o_in_ready is high; all buttons are judged in parallel lanes and one
// merge stage resolves repeat conflicts and picks the event within the same cycle
// a two-entry output buffer keeps input ready while a result waits downstream
// reset (synchronous, active low): hold timers, masks and buffers clear, registers
// take their defaults (delay 20, interval 5, combination window 3, masks 0)
module button_auto_repeat_qualifier #(
    parameter int BUTTONS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bar_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bar_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bar_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [7:0]                   i_cfg_data
);
    import bar_pkg::*;

    localparam logic [MASK_W-1:0] ALL = MASK_W'((1 << BUTTONS) - 1);

    logic [7:0] r_delay, r_interval, r_window;
    logic [7:0] r_enable, r_conflict, r_pair_a, r_pair_b;

    logic [MASK_W-1:0] r_ign, r_ra, r_proc;
    logic [MASK_W-1:0] n_ra, n_proc;

    logic      r_out_v, r_skid_v;
    t_out_item r_out, r_skid;

    logic              push, pop, tick;
    logic [MASK_W-1:0] raw, cur;
    logic [HOLD_W:0]   thresh;
    t_out_item         res, tick_res;

    t_lane_info [BUTTONS-1:0] w_info;
    t_tmr_op    [BUTTONS-1:0] w_tmr_op;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_v;
    assign push        = i_in_valid && o_in_ready;
    assign pop         = r_out_v && i_out_ready;
    assign tick        = push && (i_in_data.op == OP_TICK);
    assign raw         = i_in_data.buttons & ALL;
    assign cur         = raw & ~r_ign;
    assign thresh      = {1'b0, r_delay} + {1'b0, r_interval};

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        bar_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cur    (cur[g]),
            .i_en     (r_enable[g]),
            .i_delay  (r_delay),
            .i_thresh (thresh),
            .i_upd    (tick),
            .i_op     (w_tmr_op[g]),
            .o_info   (w_info[g])
        );
    end

    bar_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .i_info     (w_info),
        .i_ra       (r_ra),
        .i_proc     (r_proc),
        .i_conflict (r_conflict),
        .i_pair_a   (r_pair_a),
        .i_pair_b   (r_pair_b),
        .i_window   (r_window),
        .o_tmr_op   (w_tmr_op),
        .o_ra       (n_ra),
        .o_proc     (n_proc),
        .o_res      (tick_res)
    );

    // an ignore request yields an all-zero result
    assign res = (i_in_data.op == OP_IGNORE) ? '0 : tick_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= RST_REPEAT_DELAY;
            r_interval <= RST_REPEAT_INTERVAL;
            r_window   <= RST_COMBO_WINDOW;
            r_enable   <= '0;
            r_conflict <= '0;
            r_pair_a   <= '0;
            r_pair_b   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REPEAT_DELAY:    r_delay    <= i_cfg_data;
                CFG_REPEAT_INTERVAL: r_interval <= i_cfg_data;
                CFG_COMBO_WINDOW:    r_window   <= i_cfg_data;
                CFG_REPEAT_ENABLE:   r_enable   <= i_cfg_data;
                CFG_REPEAT_CONFLICT: r_conflict <= i_cfg_data;
                CFG_PAIR_A:          r_pair_a   <= i_cfg_data;
                CFG_PAIR_B:          r_pair_b   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign  <= '0;
            r_ra   <= '0;
            r_proc <= '0;
        end else if (push) begin
            if (i_in_data.op == OP_IGNORE) begin
                r_ign <= raw;
            end else begin
                r_ign  <= r_ign & raw;
                r_ra   <= n_ra;
                r_proc <= n_proc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= push;
            end
        end else if (push) begin
            if (!r_out_v) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (push) begin
            if (!r_out_v) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output stage empty");

    a_event_or_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.event_valid && o_out_data.combo_wait))
        else $error("event chosen during combination wait");

    a_event_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_valid) |->
            ((o_out_data.click_mask | o_out_data.repeat_mask) != '0))
        else $error("event without any click or repeat");

    a_state_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_ra | r_proc | r_ign) & ~ALL) == '0)
        else $error("state bit set for an absent button");

endmodule

### dv/button_auto_repeat_qualifier_test.sv
`timescale 1ns / 1ps

module button_auto_repeat_qualifier_test;
    import bar_pkg::*;

    localparam logic [CFG_W-1:0] CFG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP   = 100;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_data   = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [CFG_W-1:0]   i_cfg_index = '0;
    logic [7:0]         i_cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_data;
    logic               o_cfg_ready;

    button_auto_repeat_qualifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predictor copy of registers and state
    logic [7:0]        rep_delay, rep_interval, combo_win;
    logic [MASK_W-1:0] en_mask, conflict_mask, pair_a, pair_b;
    logic [MASK_W-1:0] ign_mask, done_mask, rpt_active;
    logic [HOLD_W-1:0] hold_cnt [MASK_W];

    t_out_item pending_events [$];
    int        n_errors   = 0;
    int        cycle_cnt  = 0;
    int        stall_left = 0;
    bit        quiet_mode = 1'b0;

    typedef struct {
        t_op               op;
        logic [MASK_W-1:0] buttons;
        bit                known;
        t_out_item         want;
    } t_stim_row;

    t_stim_row stim_rows [$];

    task automatic reset_qualifier();
        rep_delay     = RST_REPEAT_DELAY;
        rep_interval  = RST_REPEAT_INTERVAL;
        combo_win     = RST_COMBO_WINDOW;
        en_mask       = '0;
        conflict_mask = '0;
        pair_a        = '0;
        pair_b        = '0;
        ign_mask      = '0;
        done_mask     = '0;
        rpt_active    = '0;
        foreach (hold_cnt[b]) hold_cnt[b] = '0;
    endtask

    task automatic apply_reg(logic [CFG_W-1:0] idx, logic [7:0] val);
        case (idx)
            CFG_REPEAT_DELAY:    rep_delay     = val;
            CFG_REPEAT_INTERVAL: rep_interval  = val;
            CFG_COMBO_WINDOW:    combo_win     = val;
            CFG_REPEAT_ENABLE:   en_mask       = val;
            CFG_REPEAT_CONFLICT: conflict_mask = val;
            CFG_PAIR_A:          pair_a        = val;
            CFG_PAIR_B:          pair_b        = val;
            default: ;
        endcase
    endtask

    function automatic t_out_item qualify_tick(t_op op, logic [MASK_W-1:0] buttons);
        t_out_item         r;
        logic [MASK_W-1:0] held, clicked, repeated, either;
        int                t, pressed, last_hold, b, idx;
        r         = '0;
        clicked   = '0;
        repeated  = '0;
        pressed   = 0;
        last_hold = 0;
        idx       = 0;
        if (op == OP_IGNORE) begin
            ign_mask = buttons;
            return r;
        end
        ign_mask &= buttons;
        held = buttons & ~ign_mask;
        for (b = 0; b < MASK_W; b++) begin
            t = hold_cnt[b];
            if (held[b]) begin
                pressed++;
                // a saturated timer freezes the button
                if (t != HOLD_MAX) begin
                    t++;
                    if (rpt_active[b]) begin
                        if (t >= int'(rep_delay) + int'(rep_interval)) begin
                            t = rep_delay;
                            repeated[b] = 1'b1;
                        end
                    end else if (t >= int'(rep_delay) && en_mask[b]) begin
                        rpt_active[b] = 1'b1;
                        if (conflict_mask != '0 &&
                            (rpt_active & conflict_mask) == conflict_mask) begin
                            rpt_active = '0;
                        end else begin
                            repeated[b] = 1'b1;
                            t = rep_delay;
                        end
                    end else if (!done_mask[b]) begin
                        last_hold = t;
                        clicked[b] = 1'b1;
                    end
                end
            end else begin
                t = 0;
                done_mask[b]  = 1'b0;
                rpt_active[b] = 1'b0;
            end
            hold_cnt[b] = HOLD_W'(t);
        end
        r.click_mask  = clicked;
        r.repeat_mask = repeated;
        if (repeated == '0 && pressed == 1 && last_hold <= int'(combo_win)) begin
            r.combo_wait = 1'b1;
            return r;
        end
        either = clicked | repeated;
        if (either == '0) return r;
        for (b = MASK_W - 1; b >= 0; b--) begin
            if (either[b]) idx = b;
        end
        done_mask[idx]     = 1'b1;
        r.event_valid      = 1'b1;
        r.event_button     = IDX_W'(idx);
        r.event_repeat     = repeated[idx];
        r.event_suppressed = (pair_a[idx] && |(rpt_active & pair_b)) ||
                             (pair_b[idx] && |(rpt_active & pair_a));
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_cnt, what, got, want);
    endtask

    task automatic check_event(t_out_item got);
        t_out_item want;
        if (pending_events.size() == 0) begin
            report_mismatch("unexpected result", int'(got), 0);
            return;
        end
        want = pending_events.pop_front();
        if (got.event_valid != want.event_valid)
            report_mismatch("event_valid", got.event_valid, want.event_valid);
        if (got.event_button != want.event_button)
            report_mismatch("event_button", got.event_button, want.event_button);
        if (got.event_repeat != want.event_repeat)
            report_mismatch("event_repeat", got.event_repeat, want.event_repeat);
        if (got.event_suppressed != want.event_suppressed)
            report_mismatch("event_suppressed", got.event_suppressed, want.event_suppressed);
        if (got.click_mask != want.click_mask)
            report_mismatch("click_mask", got.click_mask, want.click_mask);
        if (got.repeat_mask != want.repeat_mask)
            report_mismatch("repeat_mask", got.repeat_mask, want.repeat_mask);
        if (got.combo_wait != want.combo_wait)
            report_mismatch("combo_wait", got.combo_wait, want.combo_wait);
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [MASK_W-1:0] few_bits();
        logic [MASK_W-1:0] m;
        int                n;
        m = '0;
        n = $urandom_range(1, 3);
        repeat (n) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
        return m;
    endfunction

    // valid is only lowered when a gap follows, so it never drops and rises in one step
    task automatic send_item(t_op op, logic [MASK_W-1:0] buttons, bit known, t_out_item want);
        t_in_item  it;
        t_out_item predicted;
        int        gap;
        it.op      = op;
        it.buttons = buttons;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = qualify_tick(op, buttons);
        pending_events.push_back(known ? want : predicted);
    endtask

    task automatic write_reg(logic [CFG_W-1:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic drain_events();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] dly, logic [7:0] ivl, logic [7:0] win,
                              logic [7:0] en, logic [7:0] cf, logic [7:0] pa,
                              logic [7:0] pb);
        drain_events();
        write_reg(CFG_REPEAT_DELAY, dly);
        write_reg(CFG_REPEAT_INTERVAL, ivl);
        write_reg(CFG_COMBO_WINDOW, win);
        write_reg(CFG_REPEAT_ENABLE, en);
        write_reg(CFG_REPEAT_CONFLICT, cf);
        write_reg(CFG_PAIR_A, pa);
        write_reg(CFG_PAIR_B, pb);
        write_reg(CFG_UNUSED, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(t_op op, logic [MASK_W-1:0] buttons, bit known, bit ev,
                           int idx, logic [MASK_W-1:0] clicks, bit wait_combo);
        t_stim_row row;
        row.op                = op;
        row.buttons           = buttons;
        row.known             = known;
        row.want              = '0;
        row.want.event_valid  = ev;
        row.want.event_button = IDX_W'(idx);
        row.want.click_mask   = clicks;
        row.want.combo_wait   = wait_combo;
        stim_rows.push_back(row);
    endtask

    task automatic run_random(int n_items);
        logic [MASK_W-1:0] base;
        int                sent, kind, len, k;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                // held combination with occasional changes and ignore requests
                base = few_bits();
                len = ($urandom_range(0, 99) < 5) ? $urandom_range(200, 300)
                                                  : $urandom_range(1, 30);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 99) < 4) begin
                        send_item(OP_IGNORE, base, 1'b0, '0);
                    end else begin
                        if ($urandom_range(0, 99) < 10)
                            base[$urandom_range(0, MASK_W - 1)] ^= 1'b1;
                        send_item(OP_TICK, base, 1'b0, '0);
                    end
                end
                sent += len;
            end else if (kind < 80) begin
                // lone press then release
                base = '0;
                base[$urandom_range(0, MASK_W - 1)] = 1'b1;
                len = $urandom_range(1, 8);
                repeat (len) send_item(OP_TICK, base, 1'b0, '0);
                send_item(OP_TICK, '0, 1'b0, '0);
                sent += len + 1;
            end else if (kind < 90) begin
                // ignore request, then buttons released one by one, with new presses now and then
                base = MASK_W'($urandom);
                send_item(OP_IGNORE, base, 1'b0, '0);
                len = $urandom_range(1, 6);
                repeat (len) begin
                    base[$urandom_range(0, MASK_W - 1)] = 1'b0;
                    if ($urandom_range(0, 3) == 0) base |= few_bits();
                    send_item(OP_TICK, base, 1'b0, '0);
                end
                sent += len + 1;
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) send_item(t_op'($urandom_range(0, 1)), MASK_W'($urandom),
                                       1'b0, '0);
                sent += len;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_event(o_out_data);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int ph;
        reset_qualifier();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at their defaults, no repeat enabled
        add_row(OP_TICK,   8'h00, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h01, 1, 0, 0, 8'h01, 1);
        add_row(OP_TICK,   8'h03, 1, 1, 0, 8'h03, 0);
        add_row(OP_TICK,   8'h03, 1, 1, 1, 8'h02, 0);
        add_row(OP_TICK,   8'h03, 1, 0, 0, 8'h00, 0);
        add_row(OP_IGNORE, 8'hFF, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'hFF, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h80, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h00, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h80, 1, 0, 0, 8'h80, 1);
        add_row(OP_TICK,   8'h80, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h80, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h80, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h81, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'hAA, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h55, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'hFF, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'hFF, 0, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h00, 0, 0, 0, 8'h00, 0);
        add_row(OP_IGNORE, 8'h0F, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h0F, 1, 0, 0, 8'h00, 0);
        add_row(OP_TICK,   8'h00, 1, 0, 0, 8'h00, 0);
        foreach (stim_rows[i])
            send_item(stim_rows[i].op, stim_rows[i].buttons, stim_rows[i].known,
                      stim_rows[i].want);

        // long holds here run the timers into saturation
        run_random(200);

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                // zero delay and zero interval: repeat on every tick
                0: set_config(8'd0, 8'd0, 8'd0, 8'hFF, 8'h00, 8'h0F, 8'hF0);
                // delay plus interval past the timer range, full conflict set
                1: set_config(8'd255, 8'd255, 8'd255, 8'hFF, 8'hFF, 8'h33, 8'hCC);
                2: set_config(8'd4, 8'd1, 8'd2, 8'h0F, 8'h03, 8'h01, 8'h02);
                3: set_config(8'd10, 8'd3, 8'd5, 8'hF0, 8'h30, 8'h10, 8'h20);
                default: set_config(8'($urandom_range(0, 40)), 8'($urandom_range(0, 12)),
                                    8'($urandom_range(0, 8)), 8'($urandom),
                                    few_bits(), 8'($urandom), 8'($urandom));
            endcase
            quiet_mode = (ph % 3 == 2);
            run_random(200);
        end

        drain_events();
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
